>>> rtl/core/okt_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// okt_pkg
// Shared types and codes for the ordered key table: request and response
// words, the token that walks the cell chain, and operation/status codes.
// ----------------------------------------------------------------------------
package okt_pkg;

   localparam int KEY_W   = 32;
   localparam int VALUE_W = 32;
   localparam int COUNT_W = 5;

   // operation codes
   localparam logic [1:0] OP_INS_KEY  = 2'd0;
   localparam logic [1:0] OP_REM_KEY  = 2'd1;
   localparam logic [1:0] OP_INS_HEAD = 2'd2;
   localparam logic [1:0] OP_REM_HEAD = 2'd3;

   // status codes
   localparam logic [1:0] ST_DONE = 2'd0;
   localparam logic [1:0] ST_DUP  = 2'd1;
   localparam logic [1:0] ST_FULL = 2'd2;
   localparam logic [1:0] ST_NONE = 2'd3;

   // token modes
   localparam logic [1:0] MODE_SEARCH = 2'd0;
   localparam logic [1:0] MODE_SHIFT  = 2'd1;
   localparam logic [1:0] MODE_PULL   = 2'd2;
   localparam logic [1:0] MODE_DONE   = 2'd3;

   typedef struct packed {
      logic [1:0]                operation;
      logic signed [KEY_W-1:0]   key;
      logic [VALUE_W-1:0]        entry_value;
   } req_type;

   typedef struct packed {
      logic [1:0]                status;
      logic signed [KEY_W-1:0]   removed_key;
      logic [VALUE_W-1:0]        removed_value;
      logic [COUNT_W-1:0]        entry_count;
   } rsp_type;

   typedef struct packed {
      logic signed [KEY_W-1:0]   key;
      logic [VALUE_W-1:0]        value;
   } entry_type;

   // Token handed from cell to cell. The carry entry is the displaced entry
   // while shifting down, and the removed entry once a remove has matched.
   typedef struct packed {
      logic                      vld;
      logic [1:0]                mode;
      logic [1:0]                status;
      entry_type                 carry;
   } tok_type;

endpackage

>>> rtl/core/okt_cell.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// okt_cell
// One slot of the table: holds one entry and acts on the command token as it
// passes, then hands the token to the next slot.
// ----------------------------------------------------------------------------
module okt_cell #(
   parameter int IDX   = 0,
   parameter int CNT_W = 5
) (
   input  logic                 clock,
   input  logic                 reset,
   input  okt_pkg::req_type     cmd,
   input  logic [CNT_W-1:0]     count,
   input  okt_pkg::tok_type     tok_i,
   input  okt_pkg::entry_type   next_ent,
   output okt_pkg::tok_type     tok_o,
   output okt_pkg::entry_type   ent_o
);
   import okt_pkg::*;

   localparam logic [CNT_W-1:0] IDX_C  = CNT_W'(IDX);
   localparam logic [CNT_W-1:0] NEXT_C = CNT_W'(IDX + 1);

   entry_type ent_ff, ent_in;
   tok_type   tok_ff, tok_in;
   logic      occ, next_occ, is_ins, match;

   assign occ      = IDX_C < count;
   assign next_occ = NEXT_C < count;
   assign is_ins   = (cmd.operation == OP_INS_KEY) || (cmd.operation == OP_INS_HEAD);
   assign match    = occ && ((cmd.operation == OP_REM_HEAD) || (ent_ff.key == cmd.key));

   always_comb begin
      ent_in = ent_ff;
      tok_in = tok_i;
      if (tok_i.vld) begin
         case (tok_i.mode)
            MODE_SEARCH: begin
               if (is_ins) begin
                  if (!occ) begin
                     ent_in.key   = cmd.key;
                     ent_in.value = cmd.entry_value;
                     tok_in.mode  = MODE_DONE;
                     tok_in.status = ST_DONE;
                     tok_in.carry = '0;
                  end else if (ent_ff.key < cmd.key) begin
                     tok_in.mode = MODE_SEARCH;
                  end else if (ent_ff.key == cmd.key) begin
                     tok_in.mode   = MODE_DONE;
                     tok_in.status = ST_DUP;
                     tok_in.carry  = '0;
                  end else begin
                     // open the gap here and push the old entry down
                     ent_in.key   = cmd.key;
                     ent_in.value = cmd.entry_value;
                     tok_in.mode  = MODE_SHIFT;
                     tok_in.carry = ent_ff;
                  end
               end else begin
                  if (!occ) begin
                     tok_in.mode   = MODE_DONE;
                     tok_in.status = ST_NONE;
                     tok_in.carry  = '0;
                  end else if (match) begin
                     tok_in.carry  = ent_ff;
                     tok_in.status = ST_DONE;
                     if (next_occ) begin
                        ent_in      = next_ent;
                        tok_in.mode = MODE_PULL;
                     end else begin
                        tok_in.mode = MODE_DONE;
                     end
                  end else begin
                     tok_in.mode = MODE_SEARCH;
                  end
               end
            end
            MODE_SHIFT: begin
               ent_in = tok_i.carry;
               if (occ) begin
                  tok_in.carry = ent_ff;
               end else begin
                  tok_in.mode   = MODE_DONE;
                  tok_in.status = ST_DONE;
                  tok_in.carry  = '0;
               end
            end
            MODE_PULL: begin
               if (next_occ) begin
                  ent_in = next_ent;
               end else begin
                  tok_in.mode = MODE_DONE;
               end
            end
            default: begin
               tok_in = tok_i;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      ent_ff <= ent_in;
      if (reset) begin
         tok_ff <= '0;
      end else begin
         tok_ff <= tok_in;
      end
   end

   assign tok_o = tok_ff;
   assign ent_o = ent_ff;

endmodule

>>> rtl/core/ordered_key_table_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ordered_key_table_top
// Bounded front-to-back table of signed keys with payloads, built as a chain
// of slot cells that a command token walks one slot per cycle.
// ----------------------------------------------------------------------------
// The table holds up to DEPTH entries in DEPTH cells. Each request word is one
// of insert by key (before the first key not smaller, rejected as duplicate if
// that key is equal), remove by key (first match from the front), insert at
// head and remove head, and each gives exactly one response word with the
// status, the removed entry (zero if none) and the count after the operation.
// One operation is in flight at a time. A full-table insert or an empty-table
// remove answers from the count alone, straight into the response register.
// Every other operation sends a token down the cell chain, one cell per clock,
// and its response word is written when the token leaves the last cell. A
// finished response waits in the output register (or in a one-word park
// register while the output register is still full), and no request is taken
// until the output register can take the next word, so the block takes no new
// request before the last one has been answered. Slot contents need no clearing
// after reset; the entry count says which slots hold data.
// ----------------------------------------------------------------------------
module ordered_key_table_top #(
   parameter int DEPTH = 16
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   input  okt_pkg::req_type  req_data,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output okt_pkg::rsp_type  rsp_data
);
   import okt_pkg::*;

   localparam int CNT_W = $clog2(DEPTH + 1);

   // control states
   localparam logic [1:0] S_IDLE = 2'd0;
   localparam logic [1:0] S_RUN  = 2'd1;
   localparam logic [1:0] S_PARK = 2'd2;

   logic [1:0]       state_ff, state_in;
   logic [CNT_W-1:0] count_ff, count_in, count_new;
   req_type          cmd_ff, cmd_in;
   logic             launch_ff, launch_in;
   logic             rsp_valid_ff, rsp_valid_in;
   rsp_type          rsp_ff, rsp_in;
   rsp_type          park_ff, park_in;

   logic             accept, slot_free, req_ins, cmd_ins, req_full, req_empty;
   rsp_type          fast_rsp, exit_rsp;

   tok_type          tok_head;
   tok_type          tok   [0:DEPTH];
   entry_type        ent   [0:DEPTH];

   // ---------------------------------------------------------------------
   // Cell chain: token enters cell 0 the cycle after acceptance
   // ---------------------------------------------------------------------
   always_comb begin
      tok_head        = '0;
      tok_head.vld    = launch_ff;
      tok_head.status = ST_DONE;
      if (cmd_ff.operation == OP_INS_HEAD) begin
         // head insert starts already shifting with the new entry in hand
         tok_head.mode        = MODE_SHIFT;
         tok_head.carry.key   = cmd_ff.key;
         tok_head.carry.value = cmd_ff.entry_value;
      end else begin
         tok_head.mode = MODE_SEARCH;
      end
   end

   assign tok[0]     = tok_head;
   assign ent[DEPTH] = '0;

   for (genvar i = 0; i < DEPTH; i++) begin : g_cell
      okt_cell #(
         .IDX   (i),
         .CNT_W (CNT_W)
      ) u_cell (
         .clock    (clock),
         .reset    (reset),
         .cmd      (cmd_ff),
         .count    (count_ff),
         .tok_i    (tok[i]),
         .next_ent (ent[i+1]),
         .tok_o    (tok[i+1]),
         .ent_o    (ent[i])
      );
   end

   // ---------------------------------------------------------------------
   // Request side and early answers
   // ---------------------------------------------------------------------
   assign slot_free = !rsp_valid_ff || rsp_ready;
   assign req_ready = (state_ff == S_IDLE) && slot_free;
   assign accept    = req_valid && req_ready;

   assign req_ins   = (req_data.operation == OP_INS_KEY) ||
                      (req_data.operation == OP_INS_HEAD);
   assign req_full  = req_ins && (count_ff == CNT_W'(DEPTH));
   assign req_empty = !req_ins && (count_ff == '0);

   always_comb begin
      fast_rsp             = '0;
      fast_rsp.status      = req_full ? ST_FULL : ST_NONE;
      fast_rsp.entry_count = COUNT_W'(count_ff);
   end

   // ---------------------------------------------------------------------
   // Token exit: a token still searching has found nothing
   // ---------------------------------------------------------------------
   assign cmd_ins = (cmd_ff.operation == OP_INS_KEY) || (cmd_ff.operation == OP_INS_HEAD);

   always_comb begin
      count_new = count_ff;
      exit_rsp  = '0;
      if (tok[DEPTH].mode == MODE_DONE) begin
         exit_rsp.status        = tok[DEPTH].status;
         exit_rsp.removed_key   = tok[DEPTH].carry.key;
         exit_rsp.removed_value = tok[DEPTH].carry.value;
         if (tok[DEPTH].status == ST_DONE) begin
            count_new = cmd_ins ? count_ff + CNT_W'(1) : count_ff - CNT_W'(1);
         end
      end else begin
         exit_rsp.status = ST_NONE;
      end
      exit_rsp.entry_count = COUNT_W'(count_new);
   end

   // ---------------------------------------------------------------------
   // Control
   // ---------------------------------------------------------------------
   always_comb begin
      state_in     = state_ff;
      count_in     = count_ff;
      cmd_in       = cmd_ff;
      launch_in    = 1'b0;
      rsp_in       = rsp_ff;
      park_in      = park_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      case (state_ff)
         S_IDLE: begin
            if (accept) begin
               cmd_in = req_data;
               if (req_full || req_empty) begin
                  rsp_in       = fast_rsp;
                  rsp_valid_in = 1'b1;
               end else begin
                  launch_in = 1'b1;
                  state_in  = S_RUN;
               end
            end
         end
         S_RUN: begin
            if (tok[DEPTH].vld) begin
               count_in = count_new;
               if (slot_free) begin
                  rsp_in       = exit_rsp;
                  rsp_valid_in = 1'b1;
                  state_in     = S_IDLE;
               end else begin
                  // hold the word until the output register drains
                  park_in  = exit_rsp;
                  state_in = S_PARK;
               end
            end
         end
         S_PARK: begin
            if (slot_free) begin
               rsp_in       = park_ff;
               rsp_valid_in = 1'b1;
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      cmd_ff  <= cmd_in;
      rsp_ff  <= rsp_in;
      park_ff <= park_in;
      if (reset) begin
         state_ff     <= S_IDLE;
         count_ff     <= '0;
         launch_ff    <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         launch_ff    <= launch_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

endmodule

>>> tb/tb_ordered_key_table_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_ordered_key_table_top
// Self-checking bench for the ordered key table: request words are driven
// through the valid/ready handshake, every accepted word is run through a
// local model of the table, and each response word is compared field by field
// with the oldest prediction. Directed edge cases come first, then long random
// runs under changing sender and receiver idle rates and back-pressure.
// ----------------------------------------------------------------------------
module tb_ordered_key_table_top;
   import okt_pkg::*;

   localparam int DEPTH      = 16;
   localparam int HALF_CYCLE = 5;
   // Far beyond the slowest legal run: ~1800 words, each walking the whole cell
   // chain, plus idle gaps, receiver stalls and the long hold-off.
   localparam int TIMEOUT_NS = 5_000_000;

   logic    clock = 1'b0;
   logic    reset = 1'b1;
   logic    req_valid = 1'b0;
   logic    req_ready;
   req_type req_data = '0;
   logic    rsp_valid;
   logic    rsp_ready = 1'b0;
   rsp_type rsp_data;

   // Idle rates in percent, set per phase by the test tasks.
   int send_idle_pct  = 0;
   int recv_stall_pct = 0;
   // Cycles the receiver still has to hold off; counted down below.
   int hold_cycles    = 0;

   int mismatch_count = 0;
   int rsp_seen       = 0;

   // Local copy of the table contents, front to back.
   logic signed [KEY_W-1:0] tbl_keys [DEPTH];
   logic [VALUE_W-1:0]      tbl_vals [DEPTH];
   int                      tbl_count = 0;

   // Predicted response words, oldest first.
   rsp_type answer_queue [$];

   ordered_key_table_top #(
      .DEPTH(DEPTH)
   ) i_dut (
      .clock    (clock),
      .reset    (reset),
      .req_valid(req_valid),
      .req_ready(req_ready),
      .req_data (req_data),
      .rsp_valid(rsp_valid),
      .rsp_ready(rsp_ready),
      .rsp_data (rsp_data)
   );

   always begin
      #HALF_CYCLE clock = 1'b1;
      #HALF_CYCLE clock = 1'b0;
   end

   // Hard stop in case the block hangs.
   initial begin
      #TIMEOUT_NS;
      $display("tb_ordered_key_table_top NOT OK");
      $finish;
   end

   // ------------------------------------------------------------------------
   // Table model: apply one operation, update the local copy and return the
   // response word the block must produce for it.
   // ------------------------------------------------------------------------
   function automatic rsp_type apply_table_op(req_type w);
      rsp_type                 r;
      logic signed [KEY_W-1:0] k;
      int                      pos;
      int                      i;
      r        = '0;
      r.status = ST_DONE;
      k        = w.key;
      pos      = 0;
      if (w.operation == OP_INS_KEY || w.operation == OP_INS_HEAD) begin
         // Full check comes first, so a full table reports full even for a
         // key that is already present.
         if (tbl_count >= DEPTH) begin
            r.status = ST_FULL;
         end else begin
            if (w.operation == OP_INS_KEY) begin
               // first entry that is not smaller, scanning from the front
               while (pos < tbl_count && tbl_keys[pos] < k) pos++;
            end
            if (w.operation == OP_INS_KEY && pos < tbl_count && tbl_keys[pos] == k) begin
               r.status = ST_DUP;
            end else begin
               for (i = tbl_count; i > pos; i--) begin
                  tbl_keys[i] = tbl_keys[i-1];
                  tbl_vals[i] = tbl_vals[i-1];
               end
               tbl_keys[pos] = k;
               tbl_vals[pos] = w.entry_value;
               tbl_count++;
            end
         end
      end else begin
         if (w.operation == OP_REM_KEY) begin
            while (pos < tbl_count && tbl_keys[pos] != k) pos++;
         end
         if (pos >= tbl_count) begin
            // empty table or no match: nothing removed, fields stay zero
            r.status = ST_NONE;
         end else begin
            r.removed_key   = tbl_keys[pos];
            r.removed_value = tbl_vals[pos];
            for (i = pos; i + 1 < tbl_count; i++) begin
               tbl_keys[i] = tbl_keys[i+1];
               tbl_vals[i] = tbl_vals[i+1];
            end
            tbl_count--;
         end
      end
      r.entry_count = COUNT_W'(tbl_count);
      return r;
   endfunction

   task automatic report_mismatch(input string msg);
      $display("%0t: mismatch on response %0d: %s", $realtime, rsp_seen, msg);
      mismatch_count++;
   endtask

   // ------------------------------------------------------------------------
   // Receiver: decide rsp_ready at each falling edge. A pending hold-off wins
   // over the random stall rate.
   // ------------------------------------------------------------------------
   always @(negedge clock) begin
      if (hold_cycles > 0) begin
         rsp_ready = 1'b0;
         hold_cycles--;
      end else begin
         rsp_ready = ($urandom_range(99) >= recv_stall_pct);
      end
   end

   // ------------------------------------------------------------------------
   // Response checker: every accepted response word is matched against the
   // oldest prediction, field by field.
   // ------------------------------------------------------------------------
   always @(posedge clock) begin
      rsp_type want;
      if (!reset && rsp_valid === 1'b1 && rsp_ready) begin
         if (answer_queue.size() == 0) begin
            report_mismatch("response word with nothing expected");
         end else begin
            want = answer_queue.pop_front();
            if (rsp_data.status !== want.status)
               report_mismatch($sformatf("status %0d, expected %0d",
                                         rsp_data.status, want.status));
            if (rsp_data.removed_key !== want.removed_key)
               report_mismatch($sformatf("removed_key %0d, expected %0d",
                                         rsp_data.removed_key, want.removed_key));
            if (rsp_data.removed_value !== want.removed_value)
               report_mismatch($sformatf("removed_value %0h, expected %0h",
                                         rsp_data.removed_value, want.removed_value));
            if (rsp_data.entry_count !== want.entry_count)
               report_mismatch($sformatf("entry_count %0d, expected %0d",
                                         rsp_data.entry_count, want.entry_count));
         end
         rsp_seen++;
      end
   end

   // ------------------------------------------------------------------------
   // Sender: offer one request word and hold it until accepted. Called and
   // left at a falling edge; valid stays high between back-to-back words.
   // ------------------------------------------------------------------------
   task automatic send_word(input logic [1:0] op, input logic signed [KEY_W-1:0] key,
                            input logic [VALUE_W-1:0] value);
      req_type w;
      w.operation   = op;
      w.key         = key;
      w.entry_value = value;
      // idle gap: drop valid for a random number of cycles
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid = 1'b0;
         @(negedge clock);
      end
      req_data  = w;
      req_valid = 1'b1;
      do @(posedge clock); while (req_ready !== 1'b1);
      // accepted at this edge: predict now so the queue keeps request order
      answer_queue.push_back(apply_table_op(w));
      @(negedge clock);
   endtask

   // Drop valid and hold until every predicted response has come back.
   task automatic wait_all_answered();
      req_valid = 1'b0;
      while (answer_queue.size() != 0) @(negedge clock);
   endtask

   // Half the keys from a small pool so that duplicates and matches are common,
   // some extremes, the rest anywhere in the signed range.
   function automatic logic signed [KEY_W-1:0] pick_key();
      int sel;
      sel = $urandom_range(99);
      if (sel < 50) return int'($urandom_range(15)) - 8;
      if (sel < 70) begin
         case ($urandom_range(5))
            0:       return 32'h8000_0000;
            1:       return 32'h8000_0001;
            2:       return 32'h7fff_fffe;
            3:       return 32'h7fff_ffff;
            4:       return 32'h0000_0000;
            default: return 32'hffff_ffff;
         endcase
      end
      return $urandom;
   endfunction

   // ------------------------------------------------------------------------
   // Test tasks
   // ------------------------------------------------------------------------

   // Empty-table removes, key extremes, duplicates, misses, and the effect of
   // head pushes that break the key order.
   task automatic test_directed_edges();
      send_idle_pct  = 0;
      recv_stall_pct = 0;
      send_word(OP_REM_HEAD, 0, 32'hffff_ffff);          // empty: not found
      send_word(OP_REM_KEY,  0, 0);                      // empty: not found
      send_word(OP_INS_KEY,  0, 32'h0000_0000);
      send_word(OP_INS_KEY,  32'sh7fff_ffff, 32'hffff_ffff);
      send_word(OP_INS_KEY,  32'sh8000_0000, 32'ha5a5_a5a5);
      send_word(OP_INS_KEY,  -1, 32'h5a5a_5a5a);
      send_word(OP_INS_KEY,  0, 32'h1234_5678);          // duplicate
      send_word(OP_REM_KEY,  12345, 0);                  // miss
      // push the largest key to the front: table is now out of order
      send_word(OP_INS_HEAD, 32'sh7fff_ffff, 32'h0000_0001);
      // first not-smaller entry is the front one; lands ahead of it
      send_word(OP_INS_KEY,  5, 32'h0000_0005);
      // minimum key again: stops at the front, so no duplicate is seen
      send_word(OP_INS_KEY,  32'sh8000_0000, 32'hdead_beef);
      send_word(OP_REM_KEY,  32'sh7fff_ffff, 0);         // first of two matches
      send_word(OP_REM_KEY,  32'sh8000_0000, 0);
      send_word(OP_REM_HEAD, 0, 0);
      send_word(OP_INS_HEAD, -1, 32'h0000_0000);         // second copy of -1
      send_word(OP_REM_KEY,  -1, 0);
      while (tbl_count > 0) send_word(OP_REM_HEAD, pick_key(), $urandom);
      send_word(OP_REM_HEAD, 0, 0);                      // empty again
      wait_all_answered();
   endtask

   // Fill to DEPTH, then check that every insert is refused as full, even for
   // a key that is present, and that the table recovers after a remove.
   task automatic test_full_table();
      send_idle_pct  = 20;
      recv_stall_pct = 20;
      while (tbl_count < DEPTH) send_word(OP_INS_HEAD, pick_key(), $urandom);
      send_word(OP_INS_KEY,  tbl_keys[0], $urandom);     // full before duplicate
      send_word(OP_INS_KEY,  pick_key(), $urandom);
      send_word(OP_INS_HEAD, pick_key(), $urandom);
      send_word(OP_REM_KEY,  tbl_keys[DEPTH-1], 0);      // tail entry
      send_word(OP_INS_KEY,  pick_key(), $urandom);
      send_word(OP_REM_HEAD, 0, 0);
      wait_all_answered();
   endtask

   // Hold the receiver off for a long stretch while words keep coming, so the
   // block fills its output side and stalls the input.
   task automatic test_backpressure();
      int n;
      send_idle_pct  = 0;
      recv_stall_pct = 0;
      hold_cycles    = 300;
      for (n = 0; n < 12; n++) begin
         send_word(2'($urandom_range(3)), pick_key(), $urandom);
      end
      wait_all_answered();
   endtask

   // Random traffic. Alternate insert-heavy and remove-heavy stretches so the
   // table swings between empty and full; pause now and then until drained.
   task automatic run_random_phase(input int n_words, input int s_idle, input int r_stall);
      int            n;
      int            sel;
      bit            filling;
      logic [1:0]    op;
      logic signed [KEY_W-1:0] key;
      send_idle_pct  = s_idle;
      recv_stall_pct = r_stall;
      filling        = 1'b1;
      for (n = 0; n < n_words; n++) begin
         if (n % 40 == 39) filling = !filling;
         if (n % 150 == 149) wait_all_answered();
         sel = $urandom_range(99);
         if (filling)
            op = (sel < 50) ? OP_INS_KEY : (sel < 70) ? OP_INS_HEAD :
                 (sel < 85) ? OP_REM_KEY : OP_REM_HEAD;
         else
            op = (sel < 15) ? OP_INS_KEY : (sel < 30) ? OP_INS_HEAD :
                 (sel < 75) ? OP_REM_KEY : OP_REM_HEAD;
         key = pick_key();
         // aim most key removes at a stored key
         if (op == OP_REM_KEY && tbl_count > 0 && $urandom_range(99) < 70)
            key = tbl_keys[$urandom_range(tbl_count - 1)];
         send_word(op, key, $urandom);
      end
      wait_all_answered();
   endtask

   // ------------------------------------------------------------------------
   // Main sequence
   // ------------------------------------------------------------------------
   initial begin
      // hold reset, then release it on a falling edge
      reset = 1'b1;
      repeat (5) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      test_directed_edges();
      test_full_table();
      test_backpressure();
      run_random_phase(440, 0, 0);     // no idling
      run_random_phase(440, 86, 0);    // sparse sender
      run_random_phase(440, 0, 86);    // slow receiver
      run_random_phase(440, 21, 21);   // both idle now and then

      // all words accepted: wait for the last answers, then let the block
      // settle so a stray extra response would still be caught
      wait_all_answered();
      repeat (4 * (DEPTH + 2)) @(posedge clock);
      if (answer_queue.size() != 0)
         report_mismatch($sformatf("%0d expected responses never arrived",
                                   answer_queue.size()));

      if (mismatch_count == 0) begin
         $display("tb_ordered_key_table_top OK");
      end else begin
         $display("tb_ordered_key_table_top NOT OK");
      end
      $finish;
   end

endmodule
